// ----- rtl/core/mswc_pkg.sv -----
package mswc_pkg;

  // Sequencer phases, encoded as seen on out_cycle_state
  typedef enum logic [2:0] {
    PH_INIT      = 3'd0,
    PH_AWAKE     = 3'd1,
    PH_WAIT_DISC = 3'd2,
    PH_SLEEP     = 3'd3,
    PH_WAIT_WAKE = 3'd4,
    PH_WAIT_CONN = 3'd5
  } phase_t;

  // Airplane mode commands
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_ON   = 2'd2
  } cmd_t;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int TICK_W     = 16;
  localparam int CNT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AWAKE_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_WAIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_TIMEOUT  = 3'd4;

  // Register defaults after reset
  localparam logic [TIME_W-1:0] RST_AWAKE_TIME   = 32'd3000;
  localparam logic [TIME_W-1:0] RST_DISC_TIMEOUT = 32'd30000;
  localparam logic [TIME_W-1:0] RST_SLEEP_TIME   = 32'd10000;
  localparam logic [TIME_W-1:0] RST_WAKE_WAIT    = 32'd10000;
  localparam logic [TIME_W-1:0] RST_CONN_TIMEOUT = 32'd30000;

endpackage

// ----- rtl/core/modem_sleep_wake_cycler_top.sv -----
// A result is valid in the cycle after its input transaction is accepted.
// Throughput: one tick per cycle unless a pending result is stalled by out_ready low;
// in_ready = !out_valid | out_ready, with a single output register and all step logic combinational.
// Reset (rst_n, synchronous, active low): phase init, elapsed time and counters
// zero, timing registers back to their defaults, no result pending.
module modem_sleep_wake_cycler_top
  import mswc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // tick channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  input  logic                  in_status_event,
  input  logic [TICK_W-1:0]     in_tick_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_airplane_cmd,
  output logic [2:0]            out_cycle_state,
  output logic [CNT_W-1:0]      out_trial_count,
  output logic [CNT_W-1:0]      out_sleep_errors,
  output logic [CNT_W-1:0]      out_wake_errors,
  output logic                  out_cycle_done
);

  // Timing registers
  logic [TIME_W-1:0] awake_time_r, disc_timeout_r, sleep_time_r, wake_wait_r, conn_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awake_time_r   <= RST_AWAKE_TIME;
      disc_timeout_r <= RST_DISC_TIMEOUT;
      sleep_time_r   <= RST_SLEEP_TIME;
      wake_wait_r    <= RST_WAKE_WAIT;
      conn_timeout_r <= RST_CONN_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AWAKE_TIME:   awake_time_r   <= cfg_wdata;
        REG_DISC_TIMEOUT: disc_timeout_r <= cfg_wdata;
        REG_SLEEP_TIME:   sleep_time_r   <= cfg_wdata;
        REG_WAKE_WAIT:    wake_wait_r    <= cfg_wdata;
        REG_CONN_TIMEOUT: conn_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state
  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]  trials_r, trials_nxt;
  logic [CNT_W-1:0]  sleep_err_r, sleep_err_nxt;
  logic [CNT_W-1:0]  wake_err_r, wake_err_nxt;

  // Result register
  logic              out_valid_r;
  cmd_t              cmd_r, cmd_nxt;
  phase_t            state_out_r;
  logic              done_r, done_nxt;

  logic              accept;
  phase_t            cur_phase;
  logic [TIME_W-1:0] limit;
  logic              timeout;
  logic              changed;
  logic [TIME_W-1:0] base;
  logic [TIME_W:0]   sum;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Restart overrides the stored phase for this tick
  assign cur_phase = in_restart ? PH_INIT : phase_r;

  // One limit per phase, one strict compare
  always_comb begin
    case (cur_phase)
      PH_AWAKE:     limit = awake_time_r;
      PH_WAIT_DISC: limit = disc_timeout_r;
      PH_SLEEP:     limit = sleep_time_r;
      PH_WAIT_WAKE: limit = wake_wait_r;
      PH_WAIT_CONN: limit = conn_timeout_r;
      default:      limit = '1;
    endcase
  end
  assign timeout = elapsed_r > limit;

  // Phase action
  always_comb begin
    phase_nxt     = cur_phase;
    trials_nxt    = trials_r;
    sleep_err_nxt = sleep_err_r;
    wake_err_nxt  = wake_err_r;
    cmd_nxt       = CMD_NONE;
    done_nxt      = 1'b0;
    changed       = 1'b0;
    case (cur_phase)
      PH_INIT: begin
        trials_nxt = (trials_r == '1) ? trials_r : trials_r + 1'b1;
        phase_nxt  = PH_AWAKE;
        changed    = 1'b1;
      end
      PH_AWAKE: begin
        if (timeout) begin
          cmd_nxt   = CMD_ON;
          phase_nxt = PH_WAIT_DISC;
          changed   = 1'b1;
        end
      end
      PH_WAIT_DISC: begin
        if (in_status_event) begin
          phase_nxt = PH_SLEEP;
          changed   = 1'b1;
        end else if (timeout) begin
          sleep_err_nxt = (sleep_err_r == '1) ? sleep_err_r : sleep_err_r + 1'b1;
          phase_nxt     = PH_WAIT_WAKE;
          changed       = 1'b1;
        end
      end
      PH_SLEEP: begin
        if (timeout) begin
          phase_nxt = PH_WAIT_WAKE;
          changed   = 1'b1;
        end
      end
      PH_WAIT_WAKE: begin
        if (timeout) begin
          cmd_nxt   = CMD_OFF;
          phase_nxt = PH_WAIT_CONN;
          changed   = 1'b1;
        end
      end
      PH_WAIT_CONN: begin
        if (in_status_event) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_INIT;
          changed   = 1'b1;
        end else if (timeout) begin
          wake_err_nxt = (wake_err_r == '1) ? wake_err_r : wake_err_r + 1'b1;
          phase_nxt    = PH_INIT;
          changed      = 1'b1;
        end
      end
      // unused codes fall back to init, elapsed kept
      default: phase_nxt = PH_INIT;
    endcase
  end

  // Elapsed time: clear on a phase change, then saturating add of the tick
  assign base        = changed ? '0 : elapsed_r;
  assign sum         = {1'b0, base} + {{(TIME_W+1-TICK_W){1'b0}}, in_tick_ms};
  assign elapsed_nxt = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_INIT;
      elapsed_r   <= '0;
      trials_r    <= '0;
      sleep_err_r <= '0;
      wake_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        elapsed_r   <= elapsed_nxt;
        trials_r    <= trials_nxt;
        sleep_err_r <= sleep_err_nxt;
        wake_err_r  <= wake_err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload side of the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= cmd_nxt;
      state_out_r <= phase_nxt;
      done_r      <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_airplane_cmd = cmd_r;
  assign out_cycle_state  = state_out_r;
  assign out_trial_count  = trials_r;
  assign out_sleep_errors = sleep_err_r;
  assign out_wake_errors  = wake_err_r;
  assign out_cycle_done   = done_r;

endmodule

// ----- rtl/core/mswc_checker.sv -----
module mswc_checker
  import mswc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_airplane_cmd,
  input logic [2:0]       out_cycle_state,
  input logic [CNT_W-1:0] out_trial_count,
  input logic             out_cycle_done
);

  // Every accepted tick yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cycle_state)
      && $stable(out_airplane_cmd) && $stable(out_trial_count))
    else $error("stalled result changed");

  // Completion pulse only on the return to init
  a_done_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_done |-> out_cycle_state == PH_INIT
      && out_airplane_cmd == CMD_NONE)
    else $error("cycle_done outside the return to init");

  // Airplane commands go with the matching wait state
  a_cmd_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_airplane_cmd != CMD_NONE |->
      (out_airplane_cmd == CMD_ON && out_cycle_state == PH_WAIT_DISC) ||
      (out_airplane_cmd == CMD_OFF && out_cycle_state == PH_WAIT_CONN))
    else $error("airplane command with wrong state");

endmodule

bind modem_sleep_wake_cycler_top mswc_checker u_mswc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_airplane_cmd (out_airplane_cmd),
  .out_cycle_state  (out_cycle_state),
  .out_trial_count  (out_trial_count),
  .out_cycle_done   (out_cycle_done)
);
